// File: rtl/packed_pixel_frame_store_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packed pixel frame store
// Each macro expects clk and rst to be visible at the point of use.
// ---------------------------------------------------------------------------
`ifndef PACKED_PIXEL_FRAME_STORE_MACROS_SVH
`define PACKED_PIXEL_FRAME_STORE_MACROS_SVH

// Same-cycle implication
`define PPFS_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("packed pixel frame store: same-cycle check failed");

// Next-cycle implication
`define PPFS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("packed pixel frame store: next-cycle check failed");

`endif

// File: rtl/ppfs_pkg.sv
// ---------------------------------------------------------------------------
// ppfs_pkg
// Shared codes and types of the packed pixel frame store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppfs_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Pixel packing modes (the spare code packs as ARGB8888)
  localparam logic [1:0] MODE_MONO   = 2'd0;
  localparam logic [1:0] MODE_RGB565 = 2'd1;
  localparam logic [1:0] MODE_ARGB   = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // Register reset values
  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;

  // Effective frame geometry, already saturated
  typedef struct packed {
    logic [7:0] w_eff;
    logic [6:0] h_eff;
    logic [1:0] mode;
  } cfg_t;

  // Where a pixel sits inside its word
  typedef struct packed {
    logic       in_frame;
    logic [4:0] bit_idx;
    logic       low_half;
  } pix_sel_t;

  // Memory port control
  typedef struct packed {
    logic en;
    logic we;
  } ram_ctl_t;

endpackage

`default_nettype wire

// File: rtl/ppfs_cfg.sv
// ---------------------------------------------------------------------------
// ppfs_cfg
// APB register bank: frame width, frame height and colour mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppfs_cfg #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ppfs_pkg::cfg_t     cfg
);
  import ppfs_pkg::*;

  // Saturation limits that fit the register widths
  localparam int WSAT = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
  localparam int HSAT = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;

  logic [7:0] frame_width;
  logic [6:0] frame_height;
  logic [1:0] color_mode;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      color_mode   <= MODE_MONO;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_WIDTH:  frame_width  <= pwdata[7:0];
        REG_HEIGHT: frame_height <= pwdata[6:0];
        REG_MODE:   color_mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {24'd0, frame_width};
      REG_HEIGHT: prdata = {25'd0, frame_height};
      REG_MODE:   prdata = {30'd0, color_mode};
      default:    prdata = 32'd0;
    endcase
  end

  // Effective geometry
  always_comb begin
    cfg.w_eff = ({24'd0, frame_width} > WSAT) ? 8'(WSAT) : frame_width;
    cfg.h_eff = ({25'd0, frame_height} > HSAT) ? 7'(HSAT) : frame_height;
    cfg.mode  = color_mode;
  end

endmodule

`default_nettype wire

// File: rtl/ppfs_decode.sv
// ---------------------------------------------------------------------------
// ppfs_decode
// Bounds check and word address / bit position of a pixel coordinate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppfs_decode #(
  parameter int MAX_WIDTH = 128,
  parameter int AW        = 13
) (
  input  logic signed [15:0]  x,
  input  logic signed [15:0]  y,
  input  ppfs_pkg::cfg_t      cfg,
  output ppfs_pkg::pix_sel_t  sel,
  output logic [AW-1:0]       addr
);
  import ppfs_pkg::*;

  logic [7:0] ux;
  logic [6:0] uy;
  logic [8:0] wpr_sum;
  logic [7:0] wpr;
  logic [7:0] word_idx;
  logic [7:0] offset;

  // Coordinates only matter once inside, where they fit these widths
  assign ux = x[7:0];
  assign uy = y[6:0];

  always_comb begin
    sel.in_frame = !x[15] && !y[15]
                && ({8'd0, cfg.w_eff} > $unsigned(x))
                && ({9'd0, cfg.h_eff} > $unsigned(y));
    sel.bit_idx  = ~ux[4:0];
    sel.low_half = ux[0];
  end

  // Words per row and word index within the row
  always_comb begin
    case (cfg.mode)
      MODE_MONO: begin
        wpr_sum  = {1'b0, cfg.w_eff} + 9'd31;
        wpr      = {4'd0, wpr_sum[8:5]};
        word_idx = {5'd0, ux[7:5]};
      end
      MODE_RGB565: begin
        wpr_sum  = {1'b0, cfg.w_eff} + 9'd1;
        wpr      = wpr_sum[8:1];
        word_idx = {1'b0, ux[7:1]};
      end
      default: begin
        wpr_sum  = {1'b0, cfg.w_eff};
        wpr      = wpr_sum[7:0];
        word_idx = ux;
      end
    endcase
  end

  // Words of a row are held in reversed order
  assign offset = wpr - 8'd1 - word_idx;
  assign addr   = AW'(uy * MAX_WIDTH) + AW'(offset);

endmodule

`default_nettype wire

// File: rtl/ppfs_ram.sv
// ---------------------------------------------------------------------------
// ppfs_ram
// Single-port word memory with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppfs_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                 clk,
  input  ppfs_pkg::ram_ctl_t   ctl,
  input  logic [AW-1:0]        addr,
  input  logic [31:0]          wdata,
  output logic [31:0]          rdata
);

  logic [31:0] mem [DEPTH];

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/packed_pixel_frame_store.sv
// ---------------------------------------------------------------------------
// packed_pixel_frame_store
// Frame store of packed pixels with write, read and clear operations.
// ---------------------------------------------------------------------------
// A pixel write or read is accepted and, if inside the frame, its word is
// read from the single-port store; in the access state a write's word is then
// modified and written back while the result is loaded into the output
// register. A stalled result holds the block in the access state. A clear
// walks the store one word a cycle. After reset the same pass zeroes the
// store, during which no item is accepted; configuration writes are taken at
// any time.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_pixel_frame_store_macros.svh"

module packed_pixel_frame_store #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         op,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic [31:0]        color,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        pixel,
  output logic               in_bounds
);
  import ppfs_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_CLEAR
  } state_t;

  state_t      state;
  cfg_t        cfg;
  pix_sel_t    sel;
  logic [AW-1:0] dec_addr;

  // Pending item
  logic [1:0]    op_q;
  logic          inside_q;
  logic [AW-1:0] addr_q;
  logic [4:0]    bit_q;
  logic          low_q;
  logic [31:0]   color_q;
  logic [1:0]    mode_q;

  logic [AW-1:0] clr_cnt;
  logic          clr_report;

  ram_ctl_t      ram_ctl;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  logic          item_accept;
  logic          slot_free;
  logic          pix_op;
  logic [31:0]   new_word;
  logic [31:0]   rd_pixel;
  logic [31:0]   pixel_val;

  ppfs_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppfs_decode #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_decode (
    .x    (x),
    .y    (y),
    .cfg  (cfg),
    .sel  (sel),
    .addr (dec_addr)
  );

  ppfs_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Handshakes
  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign slot_free   = !result_valid || !result_stall;
  assign pix_op      = (op == OP_WRITE) || (op == OP_READ);

  // Modify the fetched word
  always_comb begin
    case (mode_q)
      MODE_MONO: begin
        rd_pixel = {31'd0, ram_rdata[bit_q]};
        new_word = ram_rdata;
        new_word[bit_q] = (color_q != 32'd0);
      end
      MODE_RGB565: begin
        if (low_q) begin
          rd_pixel = {16'd0, ram_rdata[15:0]};
          new_word = {ram_rdata[31:16], color_q[15:0]};
        end else begin
          rd_pixel = {16'd0, ram_rdata[31:16]};
          new_word = {color_q[15:0], ram_rdata[15:0]};
        end
      end
      default: begin
        rd_pixel = ram_rdata;
        new_word = color_q;
      end
    endcase
    pixel_val = (op_q == OP_READ && inside_q) ? rd_pixel : 32'd0;
  end

  // Memory port: fetch on accept, write back in the access cycle, or clear
  always_comb begin
    ram_ctl   = '0;
    ram_addr  = dec_addr;
    ram_wdata = new_word;
    case (state)
      ST_IDLE: begin
        ram_ctl.en = item_accept && pix_op && sel.in_frame;
      end
      ST_ACCESS: begin
        ram_addr = addr_q;
        if (slot_free && op_q == OP_WRITE && inside_q) begin
          ram_ctl.en = 1'b1;
          ram_ctl.we = 1'b1;
        end
      end
      ST_CLEAR: begin
        ram_ctl.en = 1'b1;
        ram_ctl.we = 1'b1;
        ram_addr   = clr_cnt;
        ram_wdata  = 32'd0;
      end
      default: ;
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      clr_report   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_accept) begin
            op_q     <= op;
            inside_q <= sel.in_frame && pix_op;
            addr_q   <= dec_addr;
            bit_q    <= sel.bit_idx;
            low_q    <= sel.low_half;
            color_q  <= color;
            mode_q   <= cfg.mode;
            if (op == OP_CLEAR) begin
              state      <= ST_CLEAR;
              clr_cnt    <= '0;
              clr_report <= 1'b1;
            end else begin
              state <= ST_ACCESS;
            end
          end
        end
        ST_ACCESS: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            pixel        <= pixel_val;
            in_bounds    <= inside_q;
            state        <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ADDR) begin
            clr_report <= 1'b0;
            state      <= clr_report ? ST_ACCESS : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PPFS_ASSERT_NEXT(a_accept_busy, item_accept, state != ST_IDLE)
  `PPFS_ASSERT_NEXT(a_clear_start, item_accept && op == OP_CLEAR,
                    state == ST_CLEAR && clr_cnt == '0 && clr_report)
  `PPFS_ASSERT_NEXT(a_result_loaded, state == ST_ACCESS && slot_free,
                    result_valid && state == ST_IDLE)
  `PPFS_ASSERT_SAME(a_oob_zero, result_valid && !in_bounds, pixel == 32'd0)

endmodule

`default_nettype wire
